// ===== src/hnm_pkg.sv =====
package hnm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_DEPTH  = 2'd1;
  localparam logic [1:0] REG_UP_COMPONENT = 2'd2;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  // Register widths and reset values
  localparam int unsigned FrameWidthW  = 12;
  localparam int unsigned FrameDepthW  = 13;
  localparam int unsigned UpW          = 16;
  localparam logic [FrameWidthW-1:0] FrameWidthRst  = 12'd256;
  localparam logic [FrameDepthW-1:0] FrameDepthRst  = 13'd256;
  localparam logic [UpW-1:0]         UpComponentRst = 16'd26;

  // Output field widths
  localparam int unsigned ColourW = 8;
  localparam int unsigned PixelXW = 11;
  localparam int unsigned PixelYW = 12;
  localparam int unsigned OutFieldsW = 3 * ColourW + PixelXW + PixelYW;
  localparam int unsigned OutDataW = ((OutFieldsW + 7) / 8) * 8;

  // Default geometry
  localparam int unsigned MaxWidthDef   = 2048;
  localparam int unsigned MaxDepthDef   = 4096;
  localparam int unsigned HeightBitsDef = 16;

  // Input kinds carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

endpackage

// ===== src/hnm_ram.sv =====
module hnm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/heightmap_normal_map.sv =====
// Channel   Direction  Words carried
// s_axis    in         tdata: height; tuser: op (0 sample, 1 drain)
// m_axis    out        tdata: red, green, blue, pixel_x, pixel_y; tlast: frame_end
// cfg       in         cfg_index_i selects the register, cfg_data_i the value
//
// One word at a time. From acceptance, a border sample goes through the two
// line-store reads to the final state and a drain word goes there directly; an
// interior sample adds three squarings on one shared multiplier and three 8-step
// restoring searches for the scaled components. The result register lets the
// next word in while a result waits. Reset clears counters and sets the
// configuration to its reset values; the line stores are not cleared. A stalled
// m_axis holds the engine in its final state until the result register frees.
module heightmap_normal_map #(
  parameter int unsigned MAX_WIDTH   = hnm_pkg::MaxWidthDef,
  parameter int unsigned MAX_DEPTH   = hnm_pkg::MaxDepthDef,
  parameter int unsigned HEIGHT_BITS = hnm_pkg::HeightBitsDef,
  localparam int unsigned InDataW = ((HEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [InDataW-1:0]           s_axis_tdata,  // height
  input  logic                         s_axis_tuser,  // op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red, green, blue, pixel_x, pixel_y, zero pad
  output logic [hnm_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,  // frame_end
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hnm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [hnm_pkg::CfgDataW-1:0]  cfg_data_i
);

  import hnm_pkg::*;

  localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned WCW = (CW > FrameWidthW) ? CW : FrameWidthW;
  localparam int unsigned DCW = (RW > FrameDepthW) ? RW : FrameDepthW;
  localparam int unsigned DW  = HEIGHT_BITS + 1;
  localparam int unsigned MW  = (DW > UpW) ? DW : UpW;
  localparam int unsigned SW  = 2 * MW;
  localparam int unsigned SSW = SW + 2;
  localparam int unsigned QW  = SW + 18;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD0  = 8'b0000_0010,
    S_RD1  = 8'b0000_0100,
    S_DIFF = 8'b0000_1000,
    S_SQ   = 8'b0001_0000,
    S_LOAD = 8'b0010_0000,
    S_STEP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [FrameWidthW-1:0] frame_width_q;
  logic [FrameDepthW-1:0] frame_depth_q;
  logic [UpW-1:0]         up_component_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [CW-1:0]          x_q;
  logic [RW-1:0]          py_q;
  logic                   emit_q, interior_q, fend_q;
  logic signed [HEIGHT_BITS-1:0] h_q, top_q;
  logic [MW-1:0]          mag_x_q, mag_z_q;
  logic [2:0]             pos_q;
  logic [SW-1:0]          sq_q [3];
  logic [SSW-1:0]         s_q;
  logic [QW-1:0]          r_q, q_q, p_q;
  logic [ColourW-1:0]     n_q;
  logic [ColourW-1:0]     res_q [3];
  logic [1:0]             comp_q;
  logic [2:0]             bit_q;

  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q;
  logic                   out_last_q;

  // Width and depth in use
  logic [WCW-1:0] w_ext;
  logic [DCW-1:0] d_ext;
  logic [CW-1:0]  w_use;
  logic [RW-1:0]  d_use;
  logic [UpW-1:0] up_use;

  always_comb begin
    w_ext = WCW'(frame_width_q);
    if (w_ext < WCW'(3)) begin
      w_ext = WCW'(3);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_ext = WCW'(MAX_WIDTH);
    end
    d_ext = DCW'(frame_depth_q);
    if (d_ext < DCW'(3)) begin
      d_ext = DCW'(3);
    end else if (d_ext > DCW'(MAX_DEPTH)) begin
      d_ext = DCW'(MAX_DEPTH);
    end
    w_use  = CW'(w_ext);
    d_use  = RW'(d_ext);
    up_use = (up_component_q == '0) ? UpW'(1) : up_component_q;
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_depth_q  <= FrameDepthRst;
      up_component_q <= UpComponentRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FrameWidthW-1:0];
        REG_FRAME_DEPTH:  frame_depth_q  <= FrameDepthW'(cfg_data_i);
        REG_UP_COMPONENT: up_component_q <= cfg_data_i[UpW-1:0];
        default: ;
      endcase
    end
  end

  // Decode the word at acceptance
  logic          in_fire;
  logic          wrap;
  logic [CW-1:0] x_cur, x_inc;
  logic [RW-1:0] y_cur;
  logic          is_drain, drain_ok, sample_ok, last_col;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wrap      = (col_q >= w_use);
    x_cur     = wrap ? '0 : col_q;
    y_cur     = (wrap && (row_q < d_use)) ? row_q + RW'(1) : row_q;
    x_inc     = x_cur + CW'(1);
    last_col  = (x_inc >= w_use);
    is_drain  = (s_axis_tuser == OP_DRAIN);
    drain_ok  = is_drain && (y_cur >= d_use);
    sample_ok = !is_drain && (y_cur < d_use);
    col_d     = x_cur;
    row_d     = y_cur;
    if (drain_ok) begin
      if (last_col) begin
        col_d = '0;
        row_d = '0;
      end else begin
        col_d = x_inc;
      end
    end else if (sample_ok) begin
      if (last_col) begin
        col_d = '0;
        row_d = y_cur + RW'(1);
      end else begin
        col_d = x_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: row above and row two above
  logic [XW-1:0]          ra_raddr, tb_raddr, x_addr;
  logic [HEIGHT_BITS-1:0] ra_rdata, tb_rdata;
  logic                   st_we;

  assign x_addr = x_q[XW-1:0];
  assign st_we  = (state_q == S_RD1);

  always_comb begin
    ra_raddr = x_addr;
    tb_raddr = x_addr;
    if (state_q == S_RD1) begin
      ra_raddr = x_addr + XW'(1);
      tb_raddr = x_addr - XW'(1);
    end
  end

  hnm_ram #(.Width(HEIGHT_BITS), .Depth(MAX_WIDTH)) u_row_above (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (x_addr),
    .wdata_i (h_q),
    .raddr_i (ra_raddr),
    .rdata_o (ra_rdata)
  );

  hnm_ram #(.Width(HEIGHT_BITS), .Depth(MAX_WIDTH)) u_row_two_above (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (x_addr),
    .wdata_i (ra_rdata),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

  // Differences and their magnitudes
  logic signed [DW-1:0] dx, dz;
  logic [DW-1:0]        dx_abs, dz_abs;

  always_comb begin
    dx     = DW'($signed(tb_rdata)) - DW'($signed(ra_rdata));
    dz     = DW'(top_q) - DW'(h_q);
    dx_abs = dx[DW-1] ? DW'(-dx) : DW'(dx);
    dz_abs = dz[DW-1] ? DW'(-dz) : DW'(dz);
  end

  // Shared squarer
  logic [MW-1:0] sq_op;
  logic [SW-1:0] sq_prod;

  always_comb begin
    case (comp_q)
      2'd0:    sq_op = mag_x_q;
      2'd1:    sq_op = MW'(up_use);
      default: sq_op = mag_z_q;
    endcase
    sq_prod = sq_op * sq_op;
  end

  // Restoring search step: largest n with n*n*s <= 65025*c*c
  logic [QW-1:0] s_ext, trial, p_add;
  logic [3:0]    sh_p, sh_s;
  logic          take;

  always_comb begin
    s_ext = QW'(s_q);
    sh_p  = {1'b0, bit_q} + 4'd1;
    sh_s  = {bit_q, 1'b0};
    trial = q_q + (p_q << sh_p) + (s_ext << sh_s);
    p_add = p_q + (s_ext << bit_q);
    take  = (trial <= r_q);
  end

  // Sequencer
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && drain_ok) begin
          state_d = S_DONE;
        end else if (in_fire && sample_ok) begin
          state_d = S_RD0;
        end
      end
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = interior_q ? S_DIFF : S_DONE;
      S_DIFF: state_d = S_SQ;
      S_SQ:   state_d = (comp_q == 2'd2) ? S_LOAD : S_SQ;
      S_LOAD: state_d = S_STEP;
      S_STEP: begin
        if (bit_q == 3'd0) begin
          state_d = (comp_q == 2'd2) ? S_DONE : S_LOAD;
        end
      end
      S_DONE: begin
        if (!emit_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_DIFF: comp_q <= '0;
        S_SQ:   comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        S_LOAD: bit_q  <= 3'd7;
        S_STEP: begin
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            comp_q <= comp_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        h_q        <= $signed(s_axis_tdata[HEIGHT_BITS-1:0]);
        x_q        <= x_cur;
        py_q       <= is_drain ? d_use - RW'(1) : y_cur - RW'(1);
        emit_q     <= drain_ok || (y_cur != '0);
        interior_q <= (y_cur >= RW'(2)) && (x_cur != '0) && !last_col;
        fend_q     <= drain_ok && last_col;
        res_q[0]   <= '0;
        res_q[1]   <= '0;
        res_q[2]   <= '0;
      end
      S_RD1:  top_q <= $signed(tb_rdata);
      S_DIFF: begin
        mag_x_q <= MW'(dx_abs);
        mag_z_q <= MW'(dz_abs);
        pos_q   <= {(!dz[DW-1] && (dz != '0)), 1'b1, (!dx[DW-1] && (dx != '0))};
      end
      S_SQ: begin
        sq_q[comp_q] <= sq_prod;
        s_q <= ((comp_q == 2'd0) ? '0 : s_q) + SSW'(sq_prod);
      end
      S_LOAD: begin
        // 65025 = 2^16 - 2^9 + 1
        r_q <= (QW'(sq_q[comp_q]) << 16) - (QW'(sq_q[comp_q]) << 9)
             + QW'(sq_q[comp_q]);
        q_q <= '0;
        p_q <= '0;
        n_q <= '0;
      end
      S_STEP: begin
        if (take) begin
          q_q <= trial;
          p_q <= p_add;
        end
        n_q <= n_q | (take ? (ColourW'(1) << bit_q) : '0);
        if (bit_q == 3'd0) begin
          res_q[comp_q] <= pos_q[comp_q] ? (n_q | ColourW'(take)) : '0;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && emit_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && emit_q && out_free) begin
      out_data_q <= OutDataW'({PixelYW'(py_q), PixelXW'(x_q),
                              res_q[2], res_q[1], res_q[0]});
      out_last_q <= fend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(MAX_WIDTH))
    else $error("column count beyond store depth");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RW'(MAX_DEPTH))
    else $error("row count beyond frame limit");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && state_q == S_DONE && emit_q) |=> out_valid_q)
    else $error("waiting result lost");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && sample_ok) |=> (state_q == S_RD0))
    else $error("accepted sample not started");

endmodule
